[hdl/lps_pkg.sv]
// Shared types, constants and codes of the LED plane PWM scanner.
package lps_pkg;

	localparam int NUM_LEDS_DEF  = 640;
	localparam int PWM_STEPS_DEF = 31;

	localparam int LANES      = 64;
	localparam int LANE_W     = 6;
	localparam int LED_IDX_W  = 10;
	localparam int LEVEL_W    = 5;
	localparam int PLANE_W    = 2;
	localparam int WORD_IDX_W = 4;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	localparam logic [PLANE_W-1:0] PLANE_RED   = 2'd0;
	localparam logic [PLANE_W-1:0] PLANE_GREEN = 2'd1;
	localparam logic [PLANE_W-1:0] PLANE_BLUE  = 2'd2;
	localparam logic [PLANE_W-1:0] PLANE_NONE  = 2'd3;

	typedef struct packed {
		logic                 action;
		logic [LED_IDX_W-1:0] led_index;
		logic [PLANE_W-1:0]   plane;
		logic [LEVEL_W-1:0]   level;
	} in_item_t;

	typedef struct packed {
		logic [WORD_IDX_W-1:0] word_index;
		logic [LANES-1:0]      led_bits;
		logic [PLANE_W-1:0]    plane_enabled;
		logic                  last_word;
	} out_item_t;

	typedef struct packed {
		logic pixel_wr;
		logic start;
		logic advance;
	} lps_cmd_t;

	typedef struct packed {
		logic out_free;
		logic last_word;
	} lps_sts_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} lps_state_t;

endpackage

[hdl/lps_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module lps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                             wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                             rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[hdl/lps_ctrl.sv]
// Controller state machine: accepts requests and sequences the word scan of a tick.
module lps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_action,
	input  lps_pkg::lps_sts_t sts,
	output lps_pkg::lps_cmd_t cmd,
	output logic              busy
);

	lps_pkg::lps_state_t state_q;
	lps_pkg::lps_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			lps_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (item_valid) begin
					if (item_action == lps_pkg::ACT_TICK) begin
						cmd.start = 1'b1;
						state_d   = lps_pkg::ST_SCAN;
					end else begin
						cmd.pixel_wr = 1'b1;
					end
				end
			end
			lps_pkg::ST_SCAN: begin
				cmd.advance = sts.out_free;
				if (sts.out_free && sts.last_word) begin
					state_d = lps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lps_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[hdl/lps_datapath.sv]
// Datapath: level lanes, sticky on-bit store, PWM counter state and result register.
module lps_datapath #(
	parameter int NUM_LEDS  = lps_pkg::NUM_LEDS_DEF,
	parameter int PWM_STEPS = lps_pkg::PWM_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lps_pkg::in_item_t  item,
	input  lps_pkg::lps_cmd_t  cmd,
	input  logic               result_stall,
	output lps_pkg::lps_sts_t  sts,
	output lps_pkg::out_item_t result,
	output logic               result_valid
);

	localparam int NUM_WORDS = (NUM_LEDS + lps_pkg::LANES - 1) / lps_pkg::LANES;
	localparam int WORD_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int LVL_DEPTH = 4 * (2 ** WORD_W);
	localparam int CNT_W     = $clog2(PWM_STEPS + 1);
	localparam int CMP_W     = (CNT_W > lps_pkg::LEVEL_W) ? CNT_W : lps_pkg::LEVEL_W;
	localparam int REM_LEDS  = NUM_LEDS % lps_pkg::LANES;
	localparam logic [lps_pkg::LANES-1:0] LAST_MASK = (REM_LEDS == 0) ? '1 :
		((lps_pkg::LANES'(1) << REM_LEDS) - lps_pkg::LANES'(1));

	logic [WORD_W-1:0]                 word_s1;
	logic [WORD_W-1:0]                 next_word;
	logic [WORD_W-1:0]                 rd_word;
	logic                              last;
	logic                              wr_ok;
	logic [lps_pkg::LEVEL_W-1:0]       wr_level;
	logic [WORD_W+1:0]                 lvl_wr_addr;
	logic [WORD_W+1:0]                 lvl_rd_addr;
	logic [lps_pkg::LEVEL_W-1:0]       lvl_rd [lps_pkg::LANES];
	logic [lps_pkg::LANES-1:0]         cmp;
	logic [lps_pkg::LANES-1:0]         on_rd;
	logic [lps_pkg::LANES-1:0]         old_bits;
	logic [lps_pkg::LANES-1:0]         new_bits;
	logic [NUM_WORDS-1:0]              on_vld_q;
	logic [CNT_W-1:0]                  step_cnt_q;
	logic [lps_pkg::PLANE_W-1:0]       scan_plane_q;
	logic [lps_pkg::PLANE_W-1:0]       enabled_q;
	logic                              active;
	logic                              wrap;
	logic                              clr;
	logic                              out_free;
	lps_pkg::out_item_t                result_q;
	logic                              result_valid_q;

	assign last      = (word_s1 == WORD_W'(NUM_WORDS - 1));
	assign next_word = last ? '0 : word_s1 + 1'b1;
	// Hold the read address while stalled so the registered read data stays on word_s1.
	assign rd_word   = cmd.start ? '0 : (cmd.advance ? next_word : word_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_s1 <= '0;
		end else if (cmd.start) begin
			word_s1 <= '0;
		end else if (cmd.advance) begin
			word_s1 <= next_word;
		end
	end

	// Pixel writes outside the panel or to the missing fourth plane are dropped.
	assign wr_ok = (32'(item.led_index) < NUM_LEDS) && (item.plane != lps_pkg::PLANE_NONE);
	assign wr_level = (32'(item.level) > PWM_STEPS) ? lps_pkg::LEVEL_W'(PWM_STEPS) : item.level;
	assign lvl_wr_addr = {item.plane, WORD_W'(item.led_index >> lps_pkg::LANE_W)};
	assign lvl_rd_addr = {scan_plane_q, rd_word};

	for (genvar b = 0; b < lps_pkg::LANES; b++) begin : g_lane
		logic lane_wr;
		logic lane_en;

		assign lane_wr = cmd.pixel_wr && wr_ok &&
			(item.led_index[lps_pkg::LANE_W-1:0] == lps_pkg::LANE_W'(b));
		assign lane_en = !last || LAST_MASK[b];

		lps_ram #(
			.WIDTH(lps_pkg::LEVEL_W),
			.DEPTH(LVL_DEPTH)
		) u_lvl (
			.clk    (clk),
			.wr_en  (lane_wr),
			.wr_addr(lvl_wr_addr),
			.wr_data(wr_level),
			.rd_addr(lvl_rd_addr),
			.rd_data(lvl_rd[b])
		);

		assign cmp[b] = lane_en && (CMP_W'(lvl_rd[b]) >= CMP_W'(step_cnt_q));
	end

	lps_ram #(
		.WIDTH(lps_pkg::LANES),
		.DEPTH(NUM_WORDS)
	) u_on (
		.clk    (clk),
		.wr_en  (cmd.advance),
		.wr_addr(word_s1),
		.wr_data(new_bits),
		.rd_addr(rd_word),
		.rd_data(on_rd)
	);

	assign active   = (scan_plane_q != lps_pkg::PLANE_NONE);
	assign wrap     = (step_cnt_q == '0);
	assign clr      = active && wrap;
	assign old_bits = on_vld_q[word_s1] ? on_rd : '0;
	assign new_bits = clr ? '0 : (old_bits | (active ? cmp : '0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_vld_q <= '0;
		end else if (cmd.advance) begin
			on_vld_q[word_s1] <= 1'b1;
		end
	end

	// The counter steps once per tick, when its last word is produced; the scan plane moves on when it wraps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_cnt_q   <= CNT_W'(PWM_STEPS);
			scan_plane_q <= lps_pkg::PLANE_RED;
			enabled_q    <= lps_pkg::PLANE_NONE;
		end else if (cmd.advance && last && active) begin
			if (wrap) begin
				step_cnt_q   <= CNT_W'(PWM_STEPS);
				enabled_q    <= scan_plane_q;
				scan_plane_q <= (scan_plane_q == lps_pkg::PLANE_BLUE) ? lps_pkg::PLANE_RED :
					scan_plane_q + 1'b1;
			end else begin
				step_cnt_q <= step_cnt_q - 1'b1;
			end
		end
	end

	assign out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			result_q.word_index    <= lps_pkg::WORD_IDX_W'(word_s1);
			result_q.led_bits      <= new_bits;
			result_q.plane_enabled <= clr ? scan_plane_q : enabled_q;
			result_q.last_word     <= last;
		end
	end

	assign sts.out_free  = out_free;
	assign sts.last_word = last;
	assign result        = result_q;
	assign result_valid  = result_valid_q;

endmodule

[hdl/led_plane_pwm_scanner.sv]
// Top level of the LED plane PWM scanner: controller plus datapath.
//
// The item channel carries one request per accepted item: a pixel write stores a level
// (clamped to PWM_STEPS) for one LED of one colour plane, and a tick runs one PWM step.
// A pixel write produces no result. Writes to plane 3 or to an LED index at or beyond
// NUM_LEDS are dropped.
// A tick produces ceil(NUM_LEDS/64) result requests, one per 64-LED word, in word order,
// with last_word set on the final one. The first word enters the result register after
// the level and on-bit memories are read; without stalls, one word follows every cycle.
// That rate is set by the level store: 64 lane memories share one read address, one
// word per cycle. The item channel stalls for the whole tick; the next item is taken
// once the last word has entered the result register, even if that word is still
// waiting to be taken.
// When the receiver stalls, the result register holds its word and the scan waits.
// Reset clears the sticky on-bits, loads the step counter with PWM_STEPS, selects red as
// the scan plane and shows no plane enabled. Level storage is not cleared: every level of
// a plane must be written before that plane is scanned.
module led_plane_pwm_scanner #(
	parameter int NUM_LEDS  = lps_pkg::NUM_LEDS_DEF,
	parameter int PWM_STEPS = lps_pkg::PWM_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  lps_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output lps_pkg::out_item_t result
);

	lps_pkg::lps_cmd_t cmd;
	lps_pkg::lps_sts_t sts;

	// The controller only sequences; all storage and arithmetic sit in the datapath.
	lps_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_action(item.action),
		.sts        (sts),
		.cmd        (cmd),
		.busy       (item_stall)
	);

	lps_datapath #(
		.NUM_LEDS (NUM_LEDS),
		.PWM_STEPS(PWM_STEPS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cmd         (cmd),
		.result_stall(result_stall),
		.sts         (sts),
		.result      (result),
		.result_valid(result_valid)
	);

endmodule

[hdl/lps_checker.sv]
// Port-level checker of the LED plane PWM scanner and its bind to the top level.
module lps_checker #(
	parameter int NUM_LEDS = lps_pkg::NUM_LEDS_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input lps_pkg::in_item_t  item,
	input logic               result_valid,
	input logic               result_stall,
	input lps_pkg::out_item_t result
);

	localparam int NUM_WORDS = (NUM_LEDS + lps_pkg::LANES - 1) / lps_pkg::LANES;
	localparam int REM_LEDS  = NUM_LEDS % lps_pkg::LANES;
	localparam logic [lps_pkg::LANES-1:0] LAST_MASK = (REM_LEDS == 0) ? '1 :
		((lps_pkg::LANES'(1) << REM_LEDS) - lps_pkg::LANES'(1));

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.action == lps_pkg::ACT_TICK |=> item_stall)
		else $error("tick accepted but item channel not stalled");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_word |->
			result.word_index == lps_pkg::WORD_IDX_W'(NUM_WORDS - 1))
		else $error("last word flagged on wrong word index");

	a_padding: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_word |-> (result.led_bits & ~LAST_MASK) == '0)
		else $error("padding bits beyond the panel are set");

endmodule

bind led_plane_pwm_scanner lps_checker #(.NUM_LEDS(NUM_LEDS)) u_lps_checker (.*);
